// ===== hw/rtl/tkm_pkg.sv =====
// Shared constants, types and helper functions of the tiled Karatsuba multiplier.
`default_nettype none
package tkm_pkg;

    localparam int TILE_X        = 8;
    localparam int TILE_Y        = 8;
    localparam int PATTERN_ORDER = 3;

    localparam int OP_W      = 32;
    localparam int PROD_W    = 64;
    localparam int NUM_TILES = PATTERN_ORDER + 1;
    localparam int NUM_PAIRS = NUM_TILES * (NUM_TILES - 1) / 2;

    localparam logic [OP_W-1:0] FULL_WORD_MASK = 32'hffffffff;

    function automatic int gcd_sub(input int a, input int b);
        int x;
        int y;
        x = a;
        y = b;
        while (x != y) begin
            if (x > y) begin
                x = x - y;
            end else begin
                y = y - x;
            end
        end
        return x;
    endfunction

    localparam int GCD_XY = gcd_sub(TILE_X, TILE_Y);
    localparam int PITCH  = (TILE_X / GCD_XY) * TILE_Y;

    localparam int DIAG_W = TILE_X + TILE_Y;
    localparam int DIFF_W = DIAG_W + 2;
    localparam int PAIR_W = DIAG_W + 1;

    typedef logic [NUM_TILES-1:0][TILE_X-1:0] t_tiles_x;
    typedef logic [NUM_TILES-1:0][TILE_Y-1:0] t_tiles_y;

    typedef struct packed {
        t_tiles_x                           a;
        t_tiles_y                           b;
        logic [NUM_PAIRS-1:0][TILE_X:0]     da;
        logic [NUM_PAIRS-1:0][TILE_Y:0]     db;
    } t_split;

    typedef struct packed {
        logic [NUM_TILES-1:0][DIAG_W-1:0]   diag;
        logic [NUM_PAIRS-1:0][DIFF_W-1:0]   dprod;
    } t_prods;

    typedef struct packed {
        logic [NUM_TILES-1:0][DIAG_W-1:0]   diag;
        logic [NUM_PAIRS-1:0][PAIR_W-1:0]   pair;
    } t_pairs;

    typedef struct packed {
        logic [PROD_W-1:0] diag_sum;
        logic [PROD_W-1:0] pair_sum;
    } t_partial;

    function automatic int pair_hi(input int p);
        int n;
        int res;
        n   = 0;
        res = 0;
        for (int i = 0; i < NUM_TILES; i++) begin
            for (int j = 0; j < i; j++) begin
                if (n == p) begin
                    res = i;
                end
                n++;
            end
        end
        return res;
    endfunction

    function automatic int pair_lo(input int p);
        int n;
        int res;
        n   = 0;
        res = 0;
        for (int i = 0; i < NUM_TILES; i++) begin
            for (int j = 0; j < i; j++) begin
                if (n == p) begin
                    res = j;
                end
                n++;
            end
        end
        return res;
    endfunction

    function automatic logic [TILE_X-1:0] tile_x(input logic [OP_W-1:0] word, input int idx);
        logic [OP_W-1:0]   w;
        logic [TILE_X-1:0] t;
        int                pos;
        w = word & FULL_WORD_MASK;
        t = '0;
        for (int k = 0; k < TILE_X; k++) begin
            pos = idx * PITCH + k;
            if (pos < OP_W) begin
                t[k] = w[pos];
            end
        end
        return t;
    endfunction

    function automatic logic [TILE_Y-1:0] tile_y(input logic [OP_W-1:0] word, input int idx);
        logic [OP_W-1:0]   w;
        logic [TILE_Y-1:0] t;
        int                pos;
        w = word & FULL_WORD_MASK;
        t = '0;
        for (int k = 0; k < TILE_Y; k++) begin
            pos = idx * PITCH + k;
            if (pos < OP_W) begin
                t[k] = w[pos];
            end
        end
        return t;
    endfunction

    function automatic logic [PROD_W-1:0] place(input logic [PROD_W-1:0] v, input int w);
        logic [PROD_W-1:0] r;
        if (w >= PROD_W) begin
            r = '0;
        end else begin
            r = v << w;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tkm_split.sv =====
// Stage one: cut the operands into tiles and form the tile differences.
`default_nettype none
module tkm_split (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output      logic                        o_ready,
    input  wire logic [tkm_pkg::OP_W-1:0]    i_x_operand,
    input  wire logic [tkm_pkg::OP_W-1:0]    i_y_operand,
    output      logic                        o_valid,
    input  wire logic                        i_ready,
    output      tkm_pkg::t_split             o_data
);

    logic            r_vld;
    tkm_pkg::t_split r_data;
    tkm_pkg::t_split n_data;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    for (genvar t = 0; t < tkm_pkg::NUM_TILES; t++) begin : g_tile
        assign n_data.a[t] = tkm_pkg::tile_x(i_x_operand, t);
        assign n_data.b[t] = tkm_pkg::tile_y(i_y_operand, t);
    end

    for (genvar p = 0; p < tkm_pkg::NUM_PAIRS; p++) begin : g_diff
        localparam int HI = tkm_pkg::pair_hi(p);
        localparam int LO = tkm_pkg::pair_lo(p);
        assign n_data.da[p] = {1'b0, n_data.a[LO]} - {1'b0, n_data.a[HI]};
        assign n_data.db[p] = {1'b0, n_data.b[HI]} - {1'b0, n_data.b[LO]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tkm_mult.sv =====
// Stage two: diagonal tile products and signed difference products.
`default_nettype none
module tkm_mult (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output      logic            o_ready,
    input  wire tkm_pkg::t_split i_data,
    output      logic            o_valid,
    input  wire logic            i_ready,
    output      tkm_pkg::t_prods o_data
);

    logic            r_vld;
    tkm_pkg::t_prods r_data;
    tkm_pkg::t_prods n_data;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    for (genvar t = 0; t < tkm_pkg::NUM_TILES; t++) begin : g_diag
        assign n_data.diag[t] = tkm_pkg::DIAG_W'(i_data.a[t]) * tkm_pkg::DIAG_W'(i_data.b[t]);
    end

    for (genvar p = 0; p < tkm_pkg::NUM_PAIRS; p++) begin : g_dprod
        logic signed [tkm_pkg::TILE_X:0]   sa;
        logic signed [tkm_pkg::TILE_Y:0]   sb;
        logic signed [tkm_pkg::DIFF_W-1:0] sp;
        assign sa = $signed(i_data.da[p]);
        assign sb = $signed(i_data.db[p]);
        assign sp = tkm_pkg::DIFF_W'(sa) * tkm_pkg::DIFF_W'(sb);
        assign n_data.dprod[p] = $unsigned(sp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tkm_combine.sv =====
// Stages three and four: Karatsuba pair sums, then weighted partial sums.
`default_nettype none
module tkm_combine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire tkm_pkg::t_prods   i_data,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      tkm_pkg::t_partial o_data
);

    logic              r_pair_vld;
    tkm_pkg::t_pairs   r_pair;
    tkm_pkg::t_pairs   n_pair;
    logic              pair_ready;

    logic              r_part_vld;
    tkm_pkg::t_partial r_part;
    tkm_pkg::t_partial n_part;

    assign pair_ready = !r_part_vld || i_ready;
    assign o_ready    = !r_pair_vld || pair_ready;
    assign o_valid    = r_part_vld;
    assign o_data     = r_part;

    assign n_pair.diag = i_data.diag;

    for (genvar p = 0; p < tkm_pkg::NUM_PAIRS; p++) begin : g_pair
        localparam int HI = tkm_pkg::pair_hi(p);
        localparam int LO = tkm_pkg::pair_lo(p);
        logic [tkm_pkg::DIFF_W-1:0] s;
        assign s = i_data.dprod[p]
                 + tkm_pkg::DIFF_W'(i_data.diag[LO])
                 + tkm_pkg::DIFF_W'(i_data.diag[HI]);
        assign n_pair.pair[p] = s[tkm_pkg::PAIR_W-1:0];
    end

    always_comb begin
        n_part.diag_sum = '0;
        for (int t = 0; t < tkm_pkg::NUM_TILES; t++) begin
            n_part.diag_sum = n_part.diag_sum
                + tkm_pkg::place(tkm_pkg::PROD_W'(r_pair.diag[t]), 2 * t * tkm_pkg::PITCH);
        end
        n_part.pair_sum = '0;
        for (int p = 0; p < tkm_pkg::NUM_PAIRS; p++) begin
            n_part.pair_sum = n_part.pair_sum
                + tkm_pkg::place(tkm_pkg::PROD_W'(r_pair.pair[p]),
                                 (tkm_pkg::pair_hi(p) + tkm_pkg::pair_lo(p)) * tkm_pkg::PITCH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_vld <= 1'b0;
            r_part_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_pair_vld <= i_valid;
            end
            if (pair_ready) begin
                r_part_vld <= r_pair_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pair <= n_pair;
        end
        if (pair_ready && r_pair_vld) begin
            r_part <= n_part;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tkm_final.sv =====
// Stage five: final add of the partial sums into the output register.
`default_nettype none
module tkm_final (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output      logic                       o_ready,
    input  wire tkm_pkg::t_partial          i_data,
    output      logic                       o_valid,
    input  wire logic                       i_ready,
    output      logic [tkm_pkg::PROD_W-1:0] o_product
);

    logic                       r_vld;
    logic [tkm_pkg::PROD_W-1:0] r_product;
    logic [tkm_pkg::PROD_W-1:0] n_product;

    assign o_ready   = !r_vld || i_ready;
    assign o_valid   = r_vld;
    assign o_product = r_product;
    assign n_product = i_data.diag_sum + i_data.pair_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_product <= n_product;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tiled_karatsuba_multiplier.sv =====
// Top level of the tiled Karatsuba multiplier.
// The block takes one request of two 32-bit unsigned operands in every cycle while the output
// is not stalled and returns the 64-bit sum of the weighted tile products: tile split, tile
// multipliers, Karatsuba pair sums, weighted partial sums and the final add are five register
// stages, each holding its own valid bit. Back-pressure from i_ready propagates
// combinationally through the stage ready chain, so a stalled output holds every stage in place
// and a bubble in any stage is filled on the next cycle.
`default_nettype none
module tiled_karatsuba_multiplier (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output      logic                       o_ready,
    input  wire logic [tkm_pkg::OP_W-1:0]   i_x_operand,
    input  wire logic [tkm_pkg::OP_W-1:0]   i_y_operand,
    output      logic                       o_valid,
    input  wire logic                       i_ready,
    output      logic [tkm_pkg::PROD_W-1:0] o_product
);

    logic              split_valid;
    logic              split_ready;
    tkm_pkg::t_split   split_data;
    logic              mult_valid;
    logic              mult_ready;
    tkm_pkg::t_prods   mult_data;
    logic              comb_valid;
    logic              comb_ready;
    tkm_pkg::t_partial comb_data;

    tkm_split u_split (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_x_operand (i_x_operand),
        .i_y_operand (i_y_operand),
        .o_valid     (split_valid),
        .i_ready     (split_ready),
        .o_data      (split_data)
    );

    tkm_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .o_ready (split_ready),
        .i_data  (split_data),
        .o_valid (mult_valid),
        .i_ready (mult_ready),
        .o_data  (mult_data)
    );

    tkm_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mult_valid),
        .o_ready (mult_ready),
        .i_data  (mult_data),
        .o_valid (comb_valid),
        .i_ready (comb_ready),
        .o_data  (comb_data)
    );

    tkm_final u_final (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (comb_valid),
        .o_ready   (comb_ready),
        .i_data    (comb_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_product (o_product)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/tkm_checker.sv =====
// Port-level assertions of the tiled Karatsuba multiplier and their bind.
`default_nettype none
module tkm_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_ready,
    input wire logic [tkm_pkg::OP_W-1:0]   i_x_operand,
    input wire logic                       o_valid,
    input wire logic                       i_ready,
    input wire logic [tkm_pkg::PROD_W-1:0] o_product
);

    logic zero_req;
    assign zero_req = i_valid && o_ready && (i_x_operand == '0);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_product))
        else $error("result changed while stalled");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("empty pipeline refused a request");

    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |-> o_ready)
        else $error("draining pipeline refused a request");

    a_zero_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(zero_req, 5) && $past(i_rst_n, 5) && $past(i_rst_n, 4) && $past(i_rst_n, 3)
        && $past(i_rst_n, 2) && $past(i_rst_n, 1)
        && $past(i_ready, 1) && $past(i_ready, 2) && $past(i_ready, 3) && $past(i_ready, 4)
        |-> o_valid && (o_product == '0))
        else $error("zero operand did not give a zero result after five cycles");

endmodule

bind tiled_karatsuba_multiplier tkm_checker u_tkm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_x_operand (i_x_operand),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_product   (o_product)
);
`default_nettype wire
